### design/nau_pkg.sv
// nau_pkg: types, constants and the scaled tanh table for the activation unit.
// Used by nau_ctrl, nau_lane and neural_activation_unit_core. No dependencies.
`default_nettype none

package nau_pkg;

  localparam int LANES      = 4;
  localparam int SEGMENTS   = 64;
  localparam int FRAC_BITS  = 12;
  localparam int DATA_W     = 16;
  localparam int T_W        = 17;
  localparam int ROM_AW     = $clog2(SEGMENTS + 1);
  localparam int P_W        = DATA_W + $clog2(SEGMENTS + 1);
  localparam int IDX_W      = P_W - 15;
  localparam int PIPE_DEPTH = 6;

  localparam logic [T_W-1:0] TANH_GAIN  = 17'd113050;
  localparam logic [T_W-1:0] DERIV_GAIN = 17'd75366;

  localparam logic signed [DATA_W-1:0] UNIT =
    (FRAC_BITS >= 15) ? 16'sd32767 : DATA_W'(1 << FRAC_BITS);

  localparam logic [1:0] KIND_TANH   = 2'd0;
  localparam logic [1:0] KIND_RELU   = 2'd1;
  localparam logic [1:0] KIND_LINEAR = 2'd2;

  localparam logic MODE_FUNC  = 1'b0;
  localparam logic MODE_DERIV = 1'b1;

  // breakpoint spacing divisor for the table argument
  localparam longint unsigned ROM_SPAN_DIV = (64'd3 * 64'(SEGMENTS)) << FRAC_BITS;

  typedef struct packed {
    logic                     mode;
    logic signed [DATA_W-1:0] x_lane0;
    logic signed [DATA_W-1:0] x_lane1;
    logic signed [DATA_W-1:0] x_lane2;
    logic signed [DATA_W-1:0] x_lane3;
  } req_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] y_lane0;
    logic signed [DATA_W-1:0] y_lane1;
    logic signed [DATA_W-1:0] y_lane2;
    logic signed [DATA_W-1:0] y_lane3;
  } rsp_t;

  typedef struct packed {
    logic       en;
    logic [1:0] kind;
  } ctrl_t;

  typedef logic [T_W-1:0] rom_arr_t [SEGMENTS + 1];

  // restoring long division, used only while building the table
  function automatic longint unsigned udiv64(longint unsigned num, longint unsigned den);
    longint unsigned quo;
    longint unsigned rem;
    quo = '0;
    rem = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[62:0], num[b]};
      quo = quo << 1;
      if (rem >= den) begin
        rem = rem - den;
        quo = quo | 64'd1;
      end
    end
    return quo;
  endfunction

  // tanh(2a/3) in Q.16 per breakpoint, via e^-2u series in Q.32
  function automatic rom_arr_t build_tanh_rom();
    rom_arr_t          rom;
    longint unsigned   v;
    longint unsigned   n;
    longint unsigned   f;
    longint unsigned   term;
    longint unsigned   r;
    longint unsigned   one;
    longint unsigned   q;
    longint            sum;
    one = 64'd4294967296;
    for (int k = 0; k <= SEGMENTS; k++) begin
      v    = udiv64(longint'(k) << 49, ROM_SPAN_DIV);
      n    = v >> 32;
      f    = v & 64'hFFFF_FFFF;
      term = one;
      sum  = longint'(one);
      for (int j = 1; j <= 16; j++) begin
        term = udiv64((term * f) >> 32, 64'(j));
        if ((j & 1) == 1) sum = sum - longint'(term);
        else sum = sum + longint'(term);
      end
      if (sum < 0) sum = 0;
      r = longint'(sum);
      if (r > one) r = one;
      if (n > 64) n = 64;
      for (longint unsigned m = 0; m < n; m++) r = (r * 64'd1580030169) >> 32;
      q = udiv64(((one - r) << 16) + ((one + r) >> 1), one + r);
      rom[k] = T_W'(q);
    end
    return rom;
  endfunction

  localparam rom_arr_t TANH_ROM = build_tanh_rom();

endpackage

`default_nettype wire

### design/neural_activation_unit_core.sv
// neural_activation_unit_core: four-lane activation unit, top level.
// Control and config in nau_ctrl, per-lane datapath in nau_lane, merge here.
// Depends on nau_pkg.
//
// Usage:
//   Requests arrive on req_valid/req_ready with req_data (mode plus four Q4.12
//   lanes); results leave on res_valid/res_ready with res_data.
//   cfg_we/cfg_wdata writes the activation kind (scaled tanh, relu, linear);
//   write it only while no request is in flight.
//   A request passes through the stages of the lane pipeline in order: table
//   read, interpolation multiply, interpolation add, gain and square
//   multiplies, derivative multiply, final rounding and select.
//   Throughput is one request per cycle while res_ready stays high.
//   When the receiver stalls, the whole pipeline holds and req_ready drops
//   in the same cycle; bubbles are not squeezed out.
//   Reset clears all stage valid flags and returns the kind to scaled tanh.
`default_nettype none

module neural_activation_unit_core (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          cfg_we,
  input  wire logic [1:0]    cfg_wdata,
  input  wire logic          req_valid,
  output logic               req_ready,
  input  wire nau_pkg::req_t req_data,
  output logic               res_valid,
  input  wire logic          res_ready,
  output nau_pkg::rsp_t      res_data
);
  import nau_pkg::*;

  ctrl_t                    ctrl;
  logic signed [DATA_W-1:0] x_arr [LANES];
  logic signed [DATA_W-1:0] y_arr [LANES];

  nau_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .ctrl      (ctrl)
  );

  assign x_arr[0] = req_data.x_lane0;
  assign x_arr[1] = req_data.x_lane1;
  assign x_arr[2] = req_data.x_lane2;
  assign x_arr[3] = req_data.x_lane3;

  for (genvar g = 0; g < LANES; g++) begin : g_lane
    nau_lane u_lane (
      .clk  (clk),
      .ctrl (ctrl),
      .mode (req_data.mode),
      .x    (x_arr[g]),
      .y    (y_arr[g])
    );
  end

  // merge lane results into one response
  assign res_data.y_lane0 = y_arr[0];
  assign res_data.y_lane1 = y_arr[1];
  assign res_data.y_lane2 = y_arr[2];
  assign res_data.y_lane3 = y_arr[3];

  a_reset_empty : assert property (@(posedge clk) rst |=> !res_valid)
    else $error("result valid straight after reset");

  a_stall_backpressure : assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |-> !req_ready)
    else $error("request taken while result is held");

  a_kind_hold : assert property (@(posedge clk) disable iff (rst)
    !cfg_we |=> $stable(ctrl.kind))
    else $error("activation kind changed without a write");

  a_held_result : assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res_data))
    else $error("held result lost or altered");

endmodule

`default_nettype wire

### design/nau_ctrl.sv
// nau_ctrl: activation kind register and the valid/stall control of the lane pipeline.
// Depends on nau_pkg.
`default_nettype none

module nau_ctrl (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_wdata,
  input  wire logic        req_valid,
  output logic             req_ready,
  output logic             res_valid,
  input  wire logic        res_ready,
  output nau_pkg::ctrl_t   ctrl
);
  import nau_pkg::*;

  logic [1:0]            kind;
  logic [PIPE_DEPTH-1:0] vld;
  logic [PIPE_DEPTH-1:0] vld_next;
  logic                  en;

  // whole pipeline advances unless the result register is held
  assign en        = !vld[PIPE_DEPTH-1] || res_ready;
  assign req_ready = en;
  assign res_valid = vld[PIPE_DEPTH-1];
  assign vld_next  = {vld[PIPE_DEPTH-2:0], req_valid};

  always_ff @(posedge clk) begin
    if (rst) begin
      kind <= KIND_TANH;
      vld  <= '0;
    end else begin
      if (cfg_we) kind <= cfg_wdata;
      if (en) vld <= vld_next;
    end
  end

  assign ctrl.en   = en;
  assign ctrl.kind = kind;

endmodule

`default_nettype wire

### design/nau_lane.sv
// nau_lane: six-stage datapath for one lane (tanh lookup, gains, relu, linear).
// Depends on nau_pkg for the table, gains and codes.
`default_nettype none

module nau_lane (
  input  wire logic                              clk,
  input  wire nau_pkg::ctrl_t                    ctrl,
  input  wire logic                              mode,
  input  wire logic signed [nau_pkg::DATA_W-1:0] x,
  output logic signed [nau_pkg::DATA_W-1:0]      y
);
  import nau_pkg::*;

  logic [DATA_W-1:0] mag;
  logic [P_W-1:0]    p;
  logic [IDX_W-1:0]  idx;
  logic [ROM_AW-1:0] addr;
  logic [T_W-1:0]    lo_c;
  logic [T_W-1:0]    hi_c;
  logic [T_W-1:0]    diff_c;
  logic [14:0]       frac_c;

  logic signed [DATA_W-1:0] x1, x2, x3, x4, x5;
  logic                     mode1, mode2, mode3, mode4, mode5;
  logic [T_W-1:0]           lo1, diff1, lo2, t3;
  logic [14:0]              frac1;
  logic [31:0]              prod2;
  logic [2*T_W-1:0]         ap4, sq4;
  logic signed [DATA_W-1:0] yt5;
  logic [T_W+32:0]          dp5;

  logic [32:0]              interp;
  logic [2*T_W:0]           ar;
  logic [2*T_W:0]           ar_s;
  logic signed [DATA_W:0]   neg_v;
  logic signed [DATA_W-1:0] yt_c;
  logic [32:0]              om;
  logic [T_W+33:0]          dr;
  logic [T_W+33:0]          ds;
  logic signed [DATA_W-1:0] yd_c;
  logic signed [DATA_W-1:0] y_next;

  // stage 1: magnitude, segment and table read
  always_comb begin
    mag    = x[DATA_W-1] ? DATA_W'(~x + 1'b1) : DATA_W'(x);
    p      = P_W'(mag) * P_W'(SEGMENTS);
    idx    = p[P_W-1:15];
    frac_c = p[14:0];
    addr   = idx[ROM_AW-1:0];
    if (idx >= IDX_W'(SEGMENTS)) begin
      lo_c   = TANH_ROM[SEGMENTS];
      hi_c   = TANH_ROM[SEGMENTS];
      frac_c = '0;
    end else begin
      lo_c = TANH_ROM[addr];
      hi_c = TANH_ROM[addr + 1'b1];
    end
    diff_c = (hi_c >= lo_c) ? hi_c - lo_c : '0;
  end

  assign interp = 33'(prod2) + 33'h4000;

  // stage 5: round, sign and clamp the activation; deriv product
  always_comb begin
    ar    = (2*T_W+1)'(ap4) + ((2*T_W+1)'(1) << (31 - FRAC_BITS));
    ar_s  = ar >> (32 - FRAC_BITS);
    neg_v = -$signed({1'b0, (ar_s > 32768) ? 16'h8000 : ar_s[DATA_W-1:0]});
    if (x4[DATA_W-1]) yt_c = neg_v[DATA_W-1:0];
    else yt_c = (ar_s > 32767) ? 16'sd32767 : $signed(ar_s[DATA_W-1:0]);
    om = 33'h1_0000_0000 - 33'(sq4);
  end

  // stage 6: round the derivative, then pick by kind and mode
  always_comb begin
    dr   = (T_W+34)'(dp5) + ((T_W+34)'(1) << (47 - FRAC_BITS));
    ds   = dr >> (48 - FRAC_BITS);
    yd_c = (ds > 32767) ? 16'sd32767 : $signed(ds[DATA_W-1:0]);
    unique case (ctrl.kind)
      KIND_TANH: y_next = (mode5 == MODE_DERIV) ? yd_c : yt5;
      KIND_RELU: begin
        if (x5 > 0) y_next = (mode5 == MODE_DERIV) ? UNIT : x5;
        else y_next = '0;
      end
      default:   y_next = (mode5 == MODE_DERIV) ? UNIT : x5;
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctrl.en) begin
      x1    <= x;
      mode1 <= mode;
      lo1   <= lo_c;
      diff1 <= diff_c;
      frac1 <= frac_c;

      x2    <= x1;
      mode2 <= mode1;
      lo2   <= lo1;
      prod2 <= 32'(diff1) * 32'(frac1);

      x3    <= x2;
      mode3 <= mode2;
      t3    <= lo2 + T_W'(interp >> 15);

      x4    <= x3;
      mode4 <= mode3;
      ap4   <= (2*T_W)'(TANH_GAIN) * (2*T_W)'(t3);
      sq4   <= (2*T_W)'(t3) * (2*T_W)'(t3);

      x5    <= x4;
      mode5 <= mode4;
      yt5   <= yt_c;
      dp5   <= (T_W+33)'(DERIV_GAIN) * (T_W+33)'(om);

      y     <= y_next;
    end
  end

endmodule

`default_nettype wire
